>>> src/pclist_pkg.sv
// ---------------------------------------------------------------------------
// pclist_pkg: shared types and codes for the positional circular list
// Command and status codes, request and response payload structs, and the
// default list capacity.
// ---------------------------------------------------------------------------
package pclist_pkg;

    // Default number of list entries
    localparam int CAPACITY_DEF = 64;

    // Width of the length field in a response
    localparam int LEN_W = 7;

    // Command codes (code 7 is unused and acts as a no-op)
    typedef enum logic [2:0] {
        CMD_INSERT_AT    = 3'd0,
        CMD_INSERT_FRONT = 3'd1,
        CMD_INSERT_END   = 3'd2,
        CMD_DELETE_AT    = 3'd3,
        CMD_DELETE_FIRST = 3'd4,
        CMD_DELETE_LAST  = 3'd5,
        CMD_READ_AT      = 3'd6
    } cmd_t;

    // Status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_INVALID = 2'd1;
    localparam logic [1:0] STAT_EMPTY   = 2'd2;
    localparam logic [1:0] STAT_FULL    = 2'd3;

    // Request payload
    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] value;
        logic [7:0]         position;
    } req_t;

    // Response payload
    typedef struct packed {
        logic [1:0]         status;
        logic [LEN_W-1:0]   length;
        logic signed [31:0] read_value;
    } rsp_t;

endpackage

>>> src/pclist_ram.sv
// ---------------------------------------------------------------------------
// pclist_ram: generic simple dual-port RAM
// One write port and one read port, read data registered and held while
// the read enable is low.
// ---------------------------------------------------------------------------
module pclist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/positional_circular_list_top.sv
// ---------------------------------------------------------------------------
// positional_circular_list_top: bounded ordered list of signed words
// Takes insert, delete and read requests by position and answers each
// with one response carrying status, new length and read word.
// ---------------------------------------------------------------------------
// The list is held densely in one RAM, head at index 0. One request is
// worked on at a time; s_ready is high only while the sequencer is idle.
// An insert or delete moves every element behind the position by one
// place through the single RAM port pair, one word per cycle, at most
// CAPACITY - 1 words per request. A read passes through S_READ, while a
// rejected or unused request goes straight to the final step S_DONE.
// The response sits in an output register, so the next request is taken
// while a response waits; the sequencer only stalls at its final step if
// the previous response has not yet been taken. No clearing pass is
// needed after reset: only entries below the current length are ever
// read.
module positional_circular_list_top #(
    parameter int CAPACITY = pclist_pkg::CAPACITY_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pclist_pkg::req_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output pclist_pkg::rsp_t  m_data
);

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int AW    = $clog2(CAPACITY);
    localparam int PW    = (CW > 8) ? CW : 8;
    localparam int LEN_W = pclist_pkg::LEN_W;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SHIFT = 4'b0010,
        S_READ  = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     mv_reg, mv_next;
    logic [AW-1:0]     rd_addr_reg, rd_addr_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     pend_addr_reg, pend_addr_next;
    logic [31:0]       word_reg, word_next;
    logic              ins_reg, ins_next;
    logic [1:0]        status_reg, status_next;
    logic              rd_flag_reg, rd_flag_next;
    logic              m_valid_reg, m_valid_next;
    pclist_pkg::rsp_t  m_data_reg, m_data_next;

    // RAM ports
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [31:0]       ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [31:0]       ram_rdata;

    // Request decode helpers
    logic [PW-1:0]     pos_w;
    logic [PW-1:0]     cnt_w;
    logic [PW-1:0]     last_w;
    logic [PW-1:0]     ins_idx_w;
    logic [PW-1:0]     del_idx_w;
    logic              list_full;
    logic              list_empty;
    logic              out_free;

    pclist_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;

    // Position clamping for inserts and deletes
    always_comb begin
        pos_w      = PW'(s_data.position);
        cnt_w      = PW'(count_reg);
        last_w     = cnt_w - PW'(1);
        list_full  = (count_reg == CW'(CAPACITY));
        list_empty = (count_reg == '0);

        case (s_data.command)
            pclist_pkg::CMD_INSERT_FRONT: ins_idx_w = '0;
            pclist_pkg::CMD_INSERT_END:   ins_idx_w = cnt_w;
            default:                      ins_idx_w = (pos_w < cnt_w) ? pos_w : cnt_w;
        endcase

        case (s_data.command)
            pclist_pkg::CMD_DELETE_FIRST: del_idx_w = '0;
            pclist_pkg::CMD_DELETE_LAST:  del_idx_w = last_w;
            default:                      del_idx_w = (pos_w < last_w) ? pos_w : last_w;
        endcase
    end

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        mv_next        = mv_reg;
        rd_addr_next   = rd_addr_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        word_next      = word_reg;
        ins_next       = ins_reg;
        status_next    = status_reg;
        rd_flag_next   = rd_flag_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;

        ram_we    = 1'b0;
        ram_waddr = pend_addr_reg;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = rd_addr_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    status_next  = pclist_pkg::STAT_OK;
                    rd_flag_next = 1'b0;
                    pend_next    = 1'b0;
                    word_next    = s_data.value;
                    state_next   = S_DONE;
                    case (s_data.command)
                        pclist_pkg::CMD_INSERT_AT,
                        pclist_pkg::CMD_INSERT_FRONT,
                        pclist_pkg::CMD_INSERT_END: begin
                            ins_next = 1'b1;
                            if (list_full) begin
                                status_next = pclist_pkg::STAT_FULL;
                            end else if (s_data.command == pclist_pkg::CMD_INSERT_AT &&
                                         list_empty && s_data.position != '0) begin
                                status_next = pclist_pkg::STAT_INVALID;
                            end else begin
                                // move elements [idx, count-1] up by one, tail first
                                idx_next     = AW'(ins_idx_w);
                                mv_next      = AW'(cnt_w - ins_idx_w);
                                rd_addr_next = AW'(last_w);
                                state_next   = S_SHIFT;
                            end
                        end
                        pclist_pkg::CMD_DELETE_AT,
                        pclist_pkg::CMD_DELETE_FIRST,
                        pclist_pkg::CMD_DELETE_LAST: begin
                            ins_next = 1'b0;
                            if (list_empty) begin
                                status_next = pclist_pkg::STAT_EMPTY;
                            end else if (s_data.command == pclist_pkg::CMD_DELETE_AT &&
                                         s_data.position != '0 &&
                                         count_reg == CW'(1)) begin
                                status_next = pclist_pkg::STAT_INVALID;
                            end else begin
                                // move elements [idx+1, count-1] down by one, head first
                                idx_next     = AW'(del_idx_w);
                                mv_next      = AW'(last_w - del_idx_w);
                                rd_addr_next = AW'(del_idx_w + PW'(1));
                                state_next   = S_SHIFT;
                            end
                        end
                        pclist_pkg::CMD_READ_AT: begin
                            if (list_empty) begin
                                status_next = pclist_pkg::STAT_EMPTY;
                            end else if (pos_w >= cnt_w) begin
                                status_next = pclist_pkg::STAT_INVALID;
                            end else begin
                                rd_flag_next = 1'b1;
                                rd_addr_next = AW'(pos_w);
                                state_next   = S_READ;
                            end
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SHIFT: begin
                // write back the word read in the previous cycle
                ram_we = pend_reg;
                if (mv_reg != '0) begin
                    ram_re         = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = ins_reg ? rd_addr_reg + AW'(1) : rd_addr_reg - AW'(1);
                    rd_addr_next   = ins_reg ? rd_addr_reg - AW'(1) : rd_addr_reg + AW'(1);
                    mv_next        = mv_reg - AW'(1);
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        if (ins_reg) begin
                            ram_we     = 1'b1;
                            ram_waddr  = idx_reg;
                            ram_wdata  = word_reg;
                            count_next = count_reg + CW'(1);
                        end else begin
                            count_next = count_reg - CW'(1);
                        end
                        state_next = S_DONE;
                    end
                end
            end

            S_READ: begin
                ram_re     = 1'b1;
                state_next = S_DONE;
            end

            S_DONE: begin
                if (out_free) begin
                    m_valid_next           = 1'b1;
                    m_data_next.status     = status_reg;
                    m_data_next.length     = LEN_W'(count_reg);
                    m_data_next.read_value = rd_flag_reg ? ram_rdata : '0;
                    state_next             = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        mv_reg        <= mv_next;
        rd_addr_reg   <= rd_addr_next;
        idx_reg       <= idx_next;
        pend_addr_reg <= pend_addr_next;
        word_reg      <= word_next;
        ins_reg       <= ins_next;
        status_reg    <= status_next;
        rd_flag_reg   <= rd_flag_next;
        m_data_reg    <= m_data_next;
    end

`ifndef SYNTHESIS
    // Length never goes past capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("list length above capacity");

    // Length moves by at most one element per request
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(count_reg) |->
            (count_reg == $past(count_reg) + CW'(1)) ||
            (count_reg == $past(count_reg) - CW'(1)))
        else $error("list length jumped");

    // Store is only written while shifting
    a_write_in_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_SHIFT))
        else $error("store written outside shift");

    // A new response is only loaded from the final step
    a_rsp_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("response raised outside final step");

    // Response can only change once taken
    a_rsp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> $stable(m_data_reg))
        else $error("pending response overwritten");
`endif

endmodule
